>>> hw/rtl/mmtp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Memory map and terminal PIA package
// Shared types, constants and helpers for the bus model and its terminal port.
// ============================================================================
package mmtp_pkg;

    localparam int RAM_BANK_BYTES = 4096;
    localparam int ROM_BYTES      = 256;
    localparam int RAM_IDX_W      = $clog2(RAM_BANK_BYTES);
    localparam int ROM_IDX_W      = $clog2(ROM_BYTES);
    localparam int OFFSET_W       = 12;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] BANK_RAM_LOW    = 4'h0;
    localparam logic [3:0] BANK_RAM_SECOND = 4'h1;
    localparam logic [3:0] BANK_PIA        = 4'hD;
    localparam logic [3:0] BANK_RAM_HIGH   = 4'hE;
    localparam logic [3:0] BANK_ROM        = 4'hF;

    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_CR       = 8'd13;
    localparam logic [6:0] CHAR_LF_7     = 7'd10;
    localparam logic [6:0] CHAR_CR_7     = 7'd13;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [7:0] KEY_STROBE    = 8'h80;

    typedef enum logic [1:0] {
        OP_IDLE    = 2'd0,
        OP_READ    = 2'd1,
        OP_WRITE   = 2'd2,
        OP_PRELOAD = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REGION_NONE,
        REGION_RAM_LOW,
        REGION_RAM_SECOND,
        REGION_RAM_HIGH,
        REGION_ROM,
        REGION_PIA
    } region_t;

    // PIA register as picked by address bits 4, 1 and 0.
    typedef enum logic [2:0] {
        PIA_KEY_DATA,
        PIA_KEY_CTRL,
        PIA_DISP_DATA,
        PIA_DISP_CTRL,
        PIA_OTHER
    } pia_sel_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        key_valid;
        logic [7:0]  key_code;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       display_valid;
        logic [6:0] display_char;
    } result_t;

    // Classified bus cycle handed from the front to the back.
    typedef struct packed {
        op_t                 op;
        region_t             region;
        pia_sel_t            pia_sel;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          write_data;
        logic                key_valid;
        logic [7:0]          key_byte;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

    function automatic logic [7:0] key_translate(input logic [7:0] code);
        logic [7:0] k;
        k = (code == CHAR_LF) ? CHAR_CR : code;
        if (k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z)
        begin
            k = k - CASE_OFFSET;
        end
        return k | KEY_STROBE;
    endfunction

endpackage

>>> hw/rtl/mmtp_front.sv
`timescale 1ns / 1ps
// ============================================================================
// Front end
// Accepts bus beats and decodes bank, PIA register and key byte.
// ============================================================================
module mmtp_front (
    input  logic            start,
    input  mmtp_pkg::item_t item,
    input  logic            queue_full,
    output logic            busy,
    output logic            push,
    output mmtp_pkg::cmd_t  cmd
);

    logic [3:0] bank;

    assign bank = item.address[15:12];
    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        cmd.op         = mmtp_pkg::op_t'(item.kind);
        cmd.offset     = item.address[mmtp_pkg::OFFSET_W-1:0];
        cmd.write_data = item.write_data;
        cmd.key_valid  = item.key_valid;
        cmd.key_byte   = mmtp_pkg::key_translate(item.key_code);

        unique case (bank)
            mmtp_pkg::BANK_RAM_LOW:    cmd.region = mmtp_pkg::REGION_RAM_LOW;
            mmtp_pkg::BANK_RAM_SECOND: cmd.region = mmtp_pkg::REGION_RAM_SECOND;
            mmtp_pkg::BANK_RAM_HIGH:   cmd.region = mmtp_pkg::REGION_RAM_HIGH;
            mmtp_pkg::BANK_ROM:        cmd.region = mmtp_pkg::REGION_ROM;
            mmtp_pkg::BANK_PIA:        cmd.region = mmtp_pkg::REGION_PIA;
            default:                   cmd.region = mmtp_pkg::REGION_NONE;
        endcase

        // The PIA only answers when address bit 4 is set.
        if (!item.address[4])
        begin
            cmd.pia_sel = mmtp_pkg::PIA_OTHER;
        end
        else
        begin
            unique case (item.address[1:0])
                2'd0:    cmd.pia_sel = mmtp_pkg::PIA_KEY_DATA;
                2'd1:    cmd.pia_sel = mmtp_pkg::PIA_KEY_CTRL;
                2'd2:    cmd.pia_sel = mmtp_pkg::PIA_DISP_DATA;
                default: cmd.pia_sel = mmtp_pkg::PIA_DISP_CTRL;
            endcase
        end
    end

endmodule

>>> hw/rtl/mmtp_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// Command queue
// Short first-in first-out buffer of decoded commands between front and back.
// ============================================================================
module mmtp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mmtp_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output mmtp_pkg::cmd_t       head,
    output mmtp_pkg::queue_ctl_t ctl
);

    mmtp_pkg::cmd_t                     entry_reg [mmtp_pkg::QUEUE_DEPTH];
    logic [mmtp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mmtp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mmtp_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                               do_push;
    logic                               do_pop;

    assign ctl.full  = (count_reg == mmtp_pkg::QUEUE_CNT_W'(mmtp_pkg::QUEUE_DEPTH));
    assign ctl.empty = (count_reg == '0);
    assign do_push   = push && !ctl.full;
    assign do_pop    = pop && !ctl.empty;
    assign ctl.pop   = do_pop;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mmtp_pkg::QUEUE_PTR_W'(mmtp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mmtp_pkg::QUEUE_PTR_W'(mmtp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/mmtp_back.sv
`timescale 1ns / 1ps
// ============================================================================
// Back end
// Carries out one decoded bus beat per cycle on the PIA and the memories.
// ============================================================================
module mmtp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  mmtp_pkg::cmd_t      cmd,
    output logic                done,
    output mmtp_pkg::result_t   result
);

    logic [7:0] ram_low    [mmtp_pkg::RAM_BANK_BYTES];
    logic [7:0] ram_second [mmtp_pkg::RAM_BANK_BYTES];
    logic [7:0] ram_high   [mmtp_pkg::RAM_BANK_BYTES];
    logic [7:0] rom        [mmtp_pkg::ROM_BYTES];

    logic [7:0] key_data_reg, key_data_next;
    logic [7:0] key_ctrl_reg, key_ctrl_next;
    logic [7:0] disp_data_reg, disp_data_next;
    logic [7:0] disp_dir_reg, disp_dir_next;
    logic [7:0] disp_ctrl_reg, disp_ctrl_next;

    logic                 done_reg;
    logic                 is_read_reg, is_read_next;
    mmtp_pkg::region_t    src_reg;
    logic [7:0]           pia_rd_reg, pia_rd_next;
    logic                 disp_valid_reg, disp_valid_next;
    logic [6:0]           disp_char_reg, disp_char_next;
    logic [7:0]           ram_low_rd_reg, ram_second_rd_reg, ram_high_rd_reg, rom_rd_reg;

    logic [mmtp_pkg::RAM_IDX_W-1:0] ram_idx;
    logic [mmtp_pkg::ROM_IDX_W-1:0] rom_idx;
    logic                           mem_write;
    logic                           rom_write;
    logic [6:0]                     disp_raw;
    logic [7:0]                     read_mux;

    assign ram_idx   = cmd.offset[mmtp_pkg::RAM_IDX_W-1:0];
    assign rom_idx   = cmd.offset[mmtp_pkg::ROM_IDX_W-1:0];
    assign mem_write = cmd_valid
                       && (cmd.op == mmtp_pkg::OP_WRITE || cmd.op == mmtp_pkg::OP_PRELOAD);
    assign rom_write = cmd_valid && (cmd.op == mmtp_pkg::OP_PRELOAD)
                       && (cmd.region == mmtp_pkg::REGION_ROM);
    assign disp_raw  = disp_data_reg[6:0] & disp_dir_reg[6:0];

    // Key arrival, then the pending display character, then the access.
    always_comb
    begin
        key_data_next   = key_data_reg;
        key_ctrl_next   = key_ctrl_reg;
        disp_data_next  = disp_data_reg;
        disp_dir_next   = disp_dir_reg;
        disp_ctrl_next  = disp_ctrl_reg;
        pia_rd_next     = '0;
        disp_valid_next = 1'b0;
        disp_char_next  = '0;
        is_read_next    = 1'b0;

        if (cmd_valid)
        begin
            if (cmd.key_valid)
            begin
                key_data_next    = cmd.key_byte;
                key_ctrl_next[7] = 1'b1;
            end

            if (disp_ctrl_reg[7])
            begin
                disp_valid_next   = 1'b1;
                disp_char_next    = (disp_raw == mmtp_pkg::CHAR_CR_7)
                                    ? mmtp_pkg::CHAR_LF_7 : disp_raw;
                disp_ctrl_next[7] = 1'b0;
            end

            is_read_next = (cmd.op == mmtp_pkg::OP_READ);

            if (cmd.region == mmtp_pkg::REGION_PIA && cmd.op == mmtp_pkg::OP_READ)
            begin
                unique case (cmd.pia_sel)
                    mmtp_pkg::PIA_KEY_DATA:
                    begin
                        pia_rd_next      = key_data_next;
                        key_ctrl_next[7] = 1'b0;
                    end
                    mmtp_pkg::PIA_KEY_CTRL:  pia_rd_next = key_ctrl_next;
                    mmtp_pkg::PIA_DISP_CTRL: pia_rd_next = disp_ctrl_next;
                    default:                 pia_rd_next = '0;
                endcase
            end
            else if (cmd.region == mmtp_pkg::REGION_PIA && cmd.op == mmtp_pkg::OP_WRITE)
            begin
                unique case (cmd.pia_sel)
                    mmtp_pkg::PIA_KEY_CTRL: key_ctrl_next = cmd.write_data;
                    mmtp_pkg::PIA_DISP_DATA:
                    begin
                        if (disp_ctrl_next[2])
                        begin
                            disp_data_next    = {1'b0, cmd.write_data[6:0]};
                            disp_ctrl_next[7] = 1'b1;
                        end
                        else
                        begin
                            disp_dir_next = cmd.write_data;
                        end
                    end
                    mmtp_pkg::PIA_DISP_CTRL: disp_ctrl_next = cmd.write_data;
                    default:                 key_ctrl_next  = key_ctrl_next;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_data_reg   <= '0;
            key_ctrl_reg   <= '0;
            disp_data_reg  <= '0;
            disp_dir_reg   <= '0;
            disp_ctrl_reg  <= '0;
            done_reg       <= 1'b0;
            is_read_reg    <= 1'b0;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            key_data_reg   <= key_data_next;
            key_ctrl_reg   <= key_ctrl_next;
            disp_data_reg  <= disp_data_next;
            disp_dir_reg   <= disp_dir_next;
            disp_ctrl_reg  <= disp_ctrl_next;
            done_reg       <= cmd_valid;
            is_read_reg    <= is_read_next;
            disp_valid_reg <= disp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= cmd.region;
        pia_rd_reg    <= pia_rd_next;
        disp_char_reg <= disp_char_next;
    end

    // Memories: one write and one registered read per bank per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_write && cmd.region == mmtp_pkg::REGION_RAM_LOW)
        begin
            ram_low[ram_idx] <= cmd.write_data;
        end
        ram_low_rd_reg <= ram_low[ram_idx];
    end

    always_ff @(posedge clk)
    begin
        if (mem_write && cmd.region == mmtp_pkg::REGION_RAM_SECOND)
        begin
            ram_second[ram_idx] <= cmd.write_data;
        end
        ram_second_rd_reg <= ram_second[ram_idx];
    end

    always_ff @(posedge clk)
    begin
        if (mem_write && cmd.region == mmtp_pkg::REGION_RAM_HIGH)
        begin
            ram_high[ram_idx] <= cmd.write_data;
        end
        ram_high_rd_reg <= ram_high[ram_idx];
    end

    always_ff @(posedge clk)
    begin
        if (rom_write)
        begin
            rom[rom_idx] <= cmd.write_data;
        end
        rom_rd_reg <= rom[rom_idx];
    end

    always_comb
    begin
        unique case (src_reg)
            mmtp_pkg::REGION_RAM_LOW:    read_mux = ram_low_rd_reg;
            mmtp_pkg::REGION_RAM_SECOND: read_mux = ram_second_rd_reg;
            mmtp_pkg::REGION_RAM_HIGH:   read_mux = ram_high_rd_reg;
            mmtp_pkg::REGION_ROM:        read_mux = rom_rd_reg;
            mmtp_pkg::REGION_PIA:        read_mux = pia_rd_reg;
            default:                     read_mux = '0;
        endcase
    end

    assign done                 = done_reg;
    assign result.read_data     = (done_reg && is_read_reg) ? read_mux : '0;
    assign result.display_valid = done_reg && disp_valid_reg;
    assign result.display_char  = done_reg ? disp_char_reg : '0;

endmodule

>>> hw/rtl/memory_map_and_terminal_pia_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Memory map and terminal PIA
// Bus side of a small 6502 computer: RAM banks, mirrored ROM, terminal PIA.
// ============================================================================
// Each accepted beat (start high while busy is low) yields exactly one result,
// shown for one cycle with done high; the receiver cannot stall it. The beat
// passes the queue entry register, then the back end's registered memory read
// and result. A new beat may be accepted every cycle:
// the back end retires one beat per cycle, limited by the single port of each
// memory bank. The decoded beat passes through a two-entry queue, and busy is
// high only when that queue is full; since the back end takes the head entry
// every cycle, the queue never holds more than one beat and busy stays low.
// The memories are not cleared at reset; read an entry only after it was
// written or preloaded.
module memory_map_and_terminal_pia_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mmtp_pkg::item_t     item,
    output logic                done,
    output mmtp_pkg::result_t   result
);

    mmtp_pkg::cmd_t       front_cmd;
    mmtp_pkg::cmd_t       head_cmd;
    mmtp_pkg::queue_ctl_t queue_ctl;
    logic                 push;

    mmtp_front u_front (
        .start      (start),
        .item       (item),
        .queue_full (queue_ctl.full),
        .busy       (busy),
        .push       (push),
        .cmd        (front_cmd)
    );

    mmtp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (!queue_ctl.empty),
        .head     (head_cmd),
        .ctl      (queue_ctl)
    );

    mmtp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_ctl.pop),
        .cmd       (head_cmd),
        .done      (done),
        .result    (result)
    );

endmodule

>>> hw/rtl/mmtp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Port checker
// Watches the top-level ports for latency and result formatting.
// ============================================================================
module mmtp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input mmtp_pkg::result_t result
);

    // Every accepted beat is followed by a result with done high.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted beat produced no result");

    // No result appears without a matching earlier accepted beat.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted beat");

    // Result ports stay quiet between strobes.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (result == '0))
        else $error("result ports active without done");

    // Carriage return is always shown as line feed.
    a_no_cr: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.display_valid |-> result.display_char != mmtp_pkg::CHAR_CR_7)
        else $error("carriage return reached the display");

endmodule

bind memory_map_and_terminal_pia_unit mmtp_checker u_checker (.*);
